FILE: sv/shanh_pkg.sv
// shared types, constants and round functions of the reduced-round nonce hash
package shanh_pkg;

    localparam int NUM_ROUNDS = 64;
    localparam int WORD_W     = 32;
    localparam int PART_W     = 64;
    localparam int RC_W       = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int RIDX_W     = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 3'd4;

    localparam logic [RC_W-1:0] ROUNDS_RESET = 7'd64;

    localparam logic [WORD_W-1:0] PAD_WORD     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MSG_LEN_BITS = 32'(36 * 8);

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [7:0][WORD_W-1:0]  v;
        logic [15:0][WORD_W-1:0] w;
    } stage_t;

    localparam logic [7:0][WORD_W-1:0] IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [WORD_W-1:0] K_TAB [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // one compression round plus one step of the message schedule
    function automatic stage_t do_round(input stage_t s, input word_t k);
        stage_t r;
        word_t  a;
        word_t  e;
        word_t  s1e;
        word_t  ch;
        word_t  s0a;
        word_t  maj;
        word_t  t1;
        word_t  t2;
        word_t  ss0;
        word_t  ss1;
        a   = s.v[0];
        e   = s.v[4];
        s1e = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch  = (e & s.v[5]) ^ (~e & s.v[6]);
        s0a = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj = (a & s.v[1]) ^ (a & s.v[2]) ^ (s.v[1] & s.v[2]);
        t1  = s.v[7] + s1e + ch + k + s.w[0];
        t2  = s0a + maj;
        r.v[7] = s.v[6];
        r.v[6] = s.v[5];
        r.v[5] = s.v[4];
        r.v[4] = s.v[3] + t1;
        r.v[3] = s.v[2];
        r.v[2] = s.v[1];
        r.v[1] = s.v[0];
        r.v[0] = t1 + t2;
        ss0 = rotr(s.w[1], 7) ^ rotr(s.w[1], 18) ^ (s.w[1] >> 3);
        ss1 = rotr(s.w[14], 17) ^ rotr(s.w[14], 19) ^ (s.w[14] >> 10);
        r.w[14:0] = s.w[15:1];
        r.w[15]   = ss1 + s.w[9] + ss0 + s.w[0];
        return r;
    endfunction

endpackage

FILE: sv/shanh_if.sv
// channel interfaces: nonce items, digest items and configuration writes
interface shanh_job_if;
    import shanh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] nonce;
    modport source (output valid, output nonce, input ready);
    modport sink   (input valid, input nonce, output ready);
endinterface

interface shanh_result_if;
    import shanh_pkg::*;
    logic              valid;
    logic              ready;
    logic [PART_W-1:0] digest_part0;
    logic [PART_W-1:0] digest_part1;
    logic [PART_W-1:0] digest_part2;
    logic [PART_W-1:0] digest_part3;
    modport source (output valid, output digest_part0, output digest_part1,
                    output digest_part2, output digest_part3, input ready);
    modport sink   (input valid, input digest_part0, input digest_part1,
                    input digest_part2, input digest_part3, output ready);
endinterface

interface shanh_cfg_if;
    import shanh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PART_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/sha256_reduced_round_nonce_hash.sv
// an accepted nonce passes through every round stage register and then the output register
// throughput: one nonce per cycle while the output is not stalled, one round stage per cycle over 64 stages
// a stalled output holds its digest while empty stages upstream keep filling
// reset clears all stage valid bits, the prefix registers and sets round_count to 64
// stage data registers are not reset
module sha256_reduced_round_nonce_hash
    import shanh_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    shanh_job_if.sink      job,
    shanh_result_if.source result,
    shanh_cfg_if.sink      cfg
);

    logic [PART_W-1:0] prefix0_reg;
    logic [PART_W-1:0] prefix1_reg;
    logic [PART_W-1:0] prefix2_reg;
    logic [PART_W-1:0] prefix3_reg;
    logic [RC_W-1:0]   round_count_reg;

    logic [NUM_ROUNDS:0] link_valid;
    logic [NUM_ROUNDS:0] link_ready;
    stage_t              link_data [NUM_ROUNDS+1];

    logic                   out_vld_reg;
    logic [7:0][WORD_W-1:0] out_reg;
    logic [7:0][WORD_W-1:0] out_next;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix0_reg     <= '0;
            prefix1_reg     <= '0;
            prefix2_reg     <= '0;
            prefix3_reg     <= '0;
            round_count_reg <= ROUNDS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PREFIX0: prefix0_reg     <= cfg.data;
                CFG_PREFIX1: prefix1_reg     <= cfg.data;
                CFG_PREFIX2: prefix2_reg     <= cfg.data;
                CFG_PREFIX3: prefix3_reg     <= cfg.data;
                CFG_ROUNDS:  round_count_reg <= cfg.data[RC_W-1:0];
                default:     ;
            endcase
        end
    end

    // message block and initial state for the first stage
    always_comb
    begin
        link_data[0].v     = IV;
        link_data[0].w[0]  = prefix0_reg[63:32];
        link_data[0].w[1]  = prefix0_reg[31:0];
        link_data[0].w[2]  = prefix1_reg[63:32];
        link_data[0].w[3]  = prefix1_reg[31:0];
        link_data[0].w[4]  = prefix2_reg[63:32];
        link_data[0].w[5]  = prefix2_reg[31:0];
        link_data[0].w[6]  = prefix3_reg[63:32];
        link_data[0].w[7]  = prefix3_reg[31:0];
        // little-endian nonce read as a big-endian word
        link_data[0].w[8]  = {job.nonce[7:0], job.nonce[15:8],
                              job.nonce[23:16], job.nonce[31:24]};
        link_data[0].w[9]  = PAD_WORD;
        link_data[0].w[10] = '0;
        link_data[0].w[11] = '0;
        link_data[0].w[12] = '0;
        link_data[0].w[13] = '0;
        link_data[0].w[14] = '0;
        link_data[0].w[15] = MSG_LEN_BITS;
    end

    assign link_valid[0] = job.valid;
    assign job.ready     = link_ready[0];

    for (genvar k = 0; k < NUM_ROUNDS; k++)
    begin : g_stage
        shanh_stage u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .round_idx   (RIDX_W'(k)),
            .round_count (round_count_reg),
            .up_valid    (link_valid[k]),
            .up_ready    (link_ready[k]),
            .up_data     (link_data[k]),
            .dn_valid    (link_valid[k+1]),
            .dn_ready    (link_ready[k+1]),
            .dn_data     (link_data[k+1])
        );
    end

    // feed-forward and output register
    assign link_ready[NUM_ROUNDS] = !out_vld_reg || result.ready;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            out_next[i] = link_data[NUM_ROUNDS].v[i] + IV[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (link_ready[NUM_ROUNDS])
        begin
            out_vld_reg <= link_valid[NUM_ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_ready[NUM_ROUNDS] && link_valid[NUM_ROUNDS])
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.digest_part0 = {out_reg[0], out_reg[1]};
    assign result.digest_part1 = {out_reg[2], out_reg[3]};
    assign result.digest_part2 = {out_reg[4], out_reg[5]};
    assign result.digest_part3 = {out_reg[6], out_reg[7]};

    // an accepted item lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid && job.ready |=> link_valid[1])
        else $error("accepted item missing from first stage");

    // the last stage moving forward fills the output register
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[NUM_ROUNDS] && link_ready[NUM_ROUNDS] |=> out_vld_reg)
        else $error("item lost between last stage and output");

    // input back-pressure only when every stage is full and the output stalls
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !job.ready |-> (&link_valid[NUM_ROUNDS:1]) && out_vld_reg && !result.ready)
        else $error("input stalled while pipeline has room");

    // a stalled output keeps its digest
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !result.ready |=> out_vld_reg && $stable(out_reg))
        else $error("stalled digest changed");

endmodule

FILE: sv/shanh_stage.sv
// one pipeline stage: a single compression round, or a pass-through beyond the round count, with its own valid bit
module shanh_stage
    import shanh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RIDX_W-1:0] round_idx,
    input  logic [RC_W-1:0]   round_count,
    input  logic              up_valid,
    output logic              up_ready,
    input  stage_t            up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output stage_t            dn_data
);

    logic   vld_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   apply;

    // rounds beyond the count pass through; later stages skip as well
    assign apply    = round_count > {1'b0, round_idx};
    assign up_ready = !vld_reg || dn_ready;

    always_comb
    begin
        if (apply)
        begin
            data_next = do_round(up_data, K_TAB[round_idx]);
        end
        else
        begin
            data_next = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule
